// ===== rtl/core/rarp_pkg.sv =====
// ----------------------------------------------------------------------------
// rarp_pkg
// shared types and constants for the array request parser
// ----------------------------------------------------------------------------
`default_nettype none

package rarp_pkg;

    // character codes
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // fixed result and configuration field widths
    localparam int IDX_W   = 4;
    localparam int OFS_W   = 16;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 5;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_COUNT      = 3'd1,
        PH_COUNT_SKIP = 3'd2,
        PH_DOLLAR     = 3'd3,
        PH_LEN        = 3'd4,
        PH_LEN_SKIP   = 3'd5,
        PH_PAYLOAD    = 3'd6,
        PH_TRAIL      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ARG        = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_ERROR      = 2'd2,
        KIND_INCOMPLETE = 2'd3
    } kind_t;

    // results of one byte: optional argument record, optional closing record
    typedef struct packed {
        logic              arg_vld;
        logic [IDX_W-1:0]  arg_index;
        logic [OFS_W-1:0]  arg_offset;
        logic [OFS_W-1:0]  arg_length;
        logic              tail_vld;
        kind_t             tail_kind;
        logic [CNT_W-1:0]  arg_count;
        logic [OFS_W-1:0]  total_length;
    } rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/resp_array_request_parser_top.sv =====
// ----------------------------------------------------------------------------
// resp_array_request_parser_top
// array request parser: reports argument offsets and lengths, then a done, error or incomplete beat
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the record queue is not full; a byte with two results needs two output beats
// a byte's result record is written into the record queue, then loaded into the output register
// the byte rate is set by the combinational parser step (multiply by ten and check)
// reset: parser back to idle, result queue emptied, max_args set to 16
`default_nettype none

module resp_array_request_parser_top
    import rarp_pkg::*;
#(
    parameter int MAX_ARGS = 16,
    parameter int LEN_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    // request byte beats
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_end_of_data,
    // result beats
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [IDX_W-1:0]       m_arg_index,
    output logic [OFS_W-1:0]       m_arg_offset,
    output logic [OFS_W-1:0]       m_arg_length,
    output logic [CNT_W-1:0]       m_arg_count,
    output logic [OFS_W-1:0]       m_total_length,
    output logic                   m_last
);

    localparam logic [CFG_W-1:0] MAX_ARGS_RESET = CFG_W'(16);

    // argument limit register
    logic [CFG_W-1:0] max_args_reg;

    // front to queue
    logic  accept, push, q_full, q_nonempty, pop;
    rec_t  push_rec, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_args_reg <= MAX_ARGS_RESET;
        end else if (cfg_wr_en) begin
            max_args_reg <= cfg_wr_data;
        end
    end

    // input side stalls only when the record queue is full
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // byte parser: one state update per accepted beat
    rarp_front #(
        .MAX_ARGS (MAX_ARGS),
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .end_of_data (s_end_of_data),
        .max_args    (max_args_reg),
        .push        (push),
        .rec         (push_rec)
    );

    // per-byte result records wait here while the output side stalls
    rarp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (head)
    );

    // sender: argument beat first, then done, error or incomplete beat
    rarp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_nonempty     (q_nonempty),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_arg_index    (m_arg_index),
        .m_arg_offset   (m_arg_offset),
        .m_arg_length   (m_arg_length),
        .m_arg_count    (m_arg_count),
        .m_total_length (m_total_length),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rarp_front.sv =====
// ----------------------------------------------------------------------------
// rarp_front
// per-byte request parser, classifies each byte and builds its result record
// ----------------------------------------------------------------------------
`default_nettype none

module rarp_front
    import rarp_pkg::*;
#(
    parameter int MAX_ARGS = 16,
    parameter int LEN_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             end_of_data,
    input  wire logic [CFG_W-1:0] max_args,
    output logic                  push,
    output rec_t                  rec
);

    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam int LW = LEN_BITS;
    localparam logic [LW-1:0] MAX_ARGS_L = LW'(MAX_ARGS);
    localparam logic [LW-1:0] ONE_L      = LW'(1);
    localparam logic [LW-1:0] TWO_L      = LW'(2);

    phase_t          phase_reg, phase_next;
    logic [LW-1:0]   accum_reg, accum_next;
    logic [CW-1:0]   expected_reg, expected_next;
    logic [CW-1:0]   cur_arg_reg, cur_arg_next;
    logic [LW-1:0]   left_reg, left_next;
    logic [LW-1:0]   pos_reg, pos_next;
    logic [LW-1:0]   start_reg, start_next;
    logic [LW-1:0]   size_reg, size_next;

    logic            is_cr, is_dollar, is_digit, num_ok, pos_full;
    logic [3:0]      digit;
    logic [LW+3:0]   accum_x10;
    logic [LW-1:0]   pos_inc, max_ext, limit, left_dec;
    logic [CW-1:0]   cur_arg_inc;
    logic            too_many, left_one;
    logic            err, done, emit_arg;
    logic [31:0]     idx_wide, ofs_wide, len_wide, cnt_wide, tot_wide;

    assign is_cr     = (data_byte == CHAR_CR);
    assign is_dollar = (data_byte == CHAR_DOLLAR);
    assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign digit     = 4'(data_byte - CHAR_ZERO);
    assign accum_x10 = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                     + {{LW{1'b0}}, digit};
    assign num_ok    = is_digit && (accum_x10[LW+3:LW] == 4'b0);
    assign pos_full  = &pos_reg;
    assign pos_inc   = pos_reg + ONE_L;
    assign max_ext   = LW'(max_args);
    assign limit     = (max_ext < MAX_ARGS_L) ? max_ext : MAX_ARGS_L;
    assign too_many  = accum_reg > limit;
    assign left_one  = (left_reg == ONE_L);
    assign left_dec  = left_reg - ONE_L;
    assign cur_arg_inc = cur_arg_reg + CW'(1);

    // byte classification
    always_comb begin
        err      = 1'b0;
        done     = 1'b0;
        emit_arg = 1'b0;
        if (phase_reg != PH_IDLE && pos_full) begin
            err = 1'b0 | 1'b1;
        end else begin
            unique case (phase_reg)
                PH_COUNT: begin
                    if (is_cr) err = too_many;
                    else       err = !num_ok;
                end
                PH_COUNT_SKIP: done = (expected_reg == '0);
                PH_DOLLAR:     err  = !is_dollar;
                PH_LEN:        err  = !is_cr && !num_ok;
                PH_TRAIL: begin
                    emit_arg = left_one;
                    done     = left_one && (cur_arg_inc >= expected_reg);
                end
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:       phase_next = PH_COUNT;
            PH_COUNT:      if (is_cr) phase_next = PH_COUNT_SKIP;
            PH_COUNT_SKIP: phase_next = PH_DOLLAR;
            PH_DOLLAR:     phase_next = PH_LEN;
            PH_LEN:        if (is_cr) phase_next = PH_LEN_SKIP;
            PH_LEN_SKIP:   phase_next = (accum_reg == '0) ? PH_TRAIL : PH_PAYLOAD;
            PH_PAYLOAD:    if (left_one) phase_next = PH_TRAIL;
            PH_TRAIL:      if (left_one) phase_next = PH_DOLLAR;
            default:       phase_next = PH_IDLE;
        endcase
        if (err || done) phase_next = PH_IDLE;
    end

    // datapath and result record
    always_comb begin
        accum_next    = accum_reg;
        expected_next = expected_reg;
        cur_arg_next  = cur_arg_reg;
        left_next     = left_reg;
        pos_next      = pos_inc;
        start_next    = start_reg;
        size_next     = size_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                accum_next    = '0;
                expected_next = '0;
                cur_arg_next  = '0;
                left_next     = '0;
                pos_next      = ONE_L;
                start_next    = '0;
                size_next     = '0;
            end
            PH_COUNT: begin
                if (is_cr) expected_next = accum_reg[CW-1:0];
                else       accum_next    = accum_x10[LW-1:0];
            end
            PH_COUNT_SKIP: cur_arg_next = '0;
            PH_DOLLAR:     accum_next   = '0;
            PH_LEN:        if (!is_cr) accum_next = accum_x10[LW-1:0];
            PH_LEN_SKIP: begin
                start_next = pos_inc;
                size_next  = accum_reg;
                left_next  = (accum_reg == '0) ? TWO_L : accum_reg;
            end
            PH_PAYLOAD:    left_next = left_one ? TWO_L : left_dec;
            PH_TRAIL: begin
                left_next = left_dec;
                if (left_one) cur_arg_next = cur_arg_inc;
            end
            default: ;
        endcase
        if (err || done) begin
            accum_next    = '0;
            expected_next = '0;
            cur_arg_next  = '0;
            left_next     = '0;
            pos_next      = '0;
            start_next    = '0;
            size_next     = '0;
        end
    end

    assign idx_wide = 32'(cur_arg_reg);
    assign ofs_wide = 32'(start_reg);
    assign len_wide = 32'(size_reg);
    assign cnt_wide = 32'(expected_reg);
    assign tot_wide = 32'(pos_inc);

    always_comb begin
        rec              = '0;
        rec.arg_vld      = emit_arg && !err;
        rec.arg_index    = idx_wide[IDX_W-1:0];
        rec.arg_offset   = ofs_wide[OFS_W-1:0];
        rec.arg_length   = len_wide[OFS_W-1:0];
        rec.tail_vld     = err || done || end_of_data;
        rec.tail_kind    = err ? KIND_ERROR : (done ? KIND_DONE : KIND_INCOMPLETE);
        rec.arg_count    = done ? cnt_wide[CNT_W-1:0] : '0;
        rec.total_length = done ? tot_wide[OFS_W-1:0] : '0;
    end

    assign push = accept && (rec.arg_vld || rec.tail_vld);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            accum_reg    <= '0;
            expected_reg <= '0;
            cur_arg_reg  <= '0;
            left_reg     <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
            size_reg     <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            expected_reg <= expected_next;
            cur_arg_reg  <= cur_arg_next;
            left_reg     <= left_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            size_reg     <= size_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rarp_queue.sv =====
// ----------------------------------------------------------------------------
// rarp_queue
// short record queue between parser and result sender
// ----------------------------------------------------------------------------
`default_nettype none

module rarp_queue
    import rarp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire rec_t push_rec,
    input  wire logic pop,
    output logic      full,
    output logic      nonempty,
    output rec_t      head
);

    rec_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rarp_back.sv =====
// ----------------------------------------------------------------------------
// rarp_back
// result sender, splits each record into beats behind an output register
// ----------------------------------------------------------------------------
`default_nettype none

module rarp_back
    import rarp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_nonempty,
    input  wire rec_t              head,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [IDX_W-1:0]       m_arg_index,
    output logic [OFS_W-1:0]       m_arg_offset,
    output logic [OFS_W-1:0]       m_arg_length,
    output logic [CNT_W-1:0]       m_arg_count,
    output logic [OFS_W-1:0]       m_total_length,
    output logic                   m_last
);

    logic              valid_reg;
    logic              sent_reg, sent_next;
    logic              load, send_arg;
    kind_t             kind_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [OFS_W-1:0]  ofs_reg, len_reg, tot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;

    assign load     = q_nonempty && (!valid_reg || m_ready);
    assign send_arg = head.arg_vld && !sent_reg;
    assign pop      = load && (!send_arg || !head.tail_vld);

    always_comb begin
        sent_next = sent_reg;
        if (load) sent_next = send_arg && head.tail_vld;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end else begin
            sent_reg <= sent_next;
            if (load)         valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
        end
    end

    // beat payload
    always_ff @(posedge aclk) begin
        if (load) begin
            if (send_arg) begin
                kind_reg <= KIND_ARG;
                idx_reg  <= head.arg_index;
                ofs_reg  <= head.arg_offset;
                len_reg  <= head.arg_length;
                cnt_reg  <= '0;
                tot_reg  <= '0;
                last_reg <= !head.tail_vld;
            end else begin
                kind_reg <= head.tail_kind;
                idx_reg  <= '0;
                ofs_reg  <= '0;
                len_reg  <= '0;
                cnt_reg  <= head.arg_count;
                tot_reg  <= head.total_length;
                last_reg <= 1'b1;
            end
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = kind_reg;
    assign m_arg_index    = idx_reg;
    assign m_arg_offset   = ofs_reg;
    assign m_arg_length   = len_reg;
    assign m_arg_count    = cnt_reg;
    assign m_total_length = tot_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire
